[hdl/hbr_pkg.sv]
package hbr_pkg;

    localparam int HBR_MAX_BINS = 16;

    localparam int SAMPLE_W  = 32;
    localparam int BIN_NUM_W = 4;
    localparam int COUNT_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_LOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLLOVER_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_ENABLE = 3'd4;

    localparam logic signed [31:0] RST_BIN_LOW        = 32'sd0;
    localparam logic [30:0]        RST_BIN_WIDTH      = 31'd1;
    localparam logic [4:0]         RST_BINS_IN_USE    = 5'd16;
    localparam logic [30:0]        RST_ROLLOVER_LIMIT = 31'h7FFF_FFFF;
    localparam logic               RST_FORWARD_ENABLE = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic clear;
        logic dump_start;
        logic dump_rd;
        logic dump_push;
        logic bin_rd;
        logic bin_wr;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic roll_due;
        logic fwd_en;
        logic dump_last;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

[hdl/hbr_if.sv]
interface hbr_sample_if import hbr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface hbr_bin_if import hbr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BIN_NUM_W-1:0] bin_number;
    logic [COUNT_W-1:0]   bin_count;
    logic                 last_bin;

    modport source (output valid, output bin_number, output bin_count, output last_bin,
                    input ready);
    modport sink   (input valid, input bin_number, input bin_count, input last_bin,
                    output ready);
endinterface

[hdl/hbr_ctrl.sv]
module hbr_ctrl import hbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROLL = 3'd1;
    localparam logic [2:0] S_DRD  = 3'd2;
    localparam logic [2:0] S_DOUT = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_BRD  = 3'd5;
    localparam logic [2:0] S_BWR  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ROLL;
                end
            end
            S_ROLL: begin
                // The total is checked before this item is counted.
                o_cmd.div_load = 1'b1;
                if (i_status.roll_due && i_status.fwd_en) begin
                    o_cmd.dump_start = 1'b1;
                    n_state          = S_DRD;
                end else begin
                    o_cmd.clear = i_status.roll_due;
                    n_state     = S_DIV;
                end
            end
            S_DRD: begin
                o_cmd.dump_rd = 1'b1;
                n_state       = S_DOUT;
            end
            S_DOUT: begin
                if (i_status.out_free) begin
                    o_cmd.dump_push = 1'b1;
                    if (i_status.dump_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_DRD;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                o_cmd.bin_rd = 1'b1;
                n_state      = S_BWR;
            end
            S_BWR: begin
                o_cmd.bin_wr = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/hbr_datapath.sv]
module hbr_datapath import hbr_pkg::*; #(
    parameter int MAX_BINS = HBR_MAX_BINS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    hbr_bin_if.source                  o_bin
);

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);

    // Configuration registers.
    logic signed [31:0] r_bin_low;
    logic [30:0]        r_bin_width;
    logic [4:0]         r_bins_in_use;
    logic [30:0]        r_roll_limit;
    logic               r_fwd_en;

    // Bin store with one valid bit per entry; an entry that is not valid reads as zero.
    logic [31:0]         r_mem [MAX_BINS];
    logic [MAX_BINS-1:0] r_valid;
    logic [31:0]         r_rd_data;
    logic                r_rd_ok;
    logic [31:0]         r_total;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic [31:0] r_quo;
    logic [30:0] r_rem;
    logic        r_neg;
    logic [4:0]  r_step;
    logic [IW-1:0] r_bin;
    logic [IW-1:0] r_idx;

    logic                 r_ovalid;
    logic [BIN_NUM_W-1:0] r_out_num;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_last;

    logic [CW-1:0] n_active;
    logic [IW-1:0] last_idx;
    logic [30:0]   width_eff;
    logic [32:0]   diff;
    logic [31:0]   shifted;
    logic [32:0]   trial;
    logic          ge;
    logic [IW-1:0] bin_sel;
    logic [IW-1:0] rd_addr;
    logic          out_free;

    always_comb begin
        if (r_bins_in_use == 5'd0) begin
            n_active = CW'(1);
        end else if (32'(r_bins_in_use) > 32'(MAX_BINS)) begin
            n_active = CW'(MAX_BINS);
        end else begin
            n_active = CW'(r_bins_in_use);
        end
    end

    assign last_idx  = IW'(n_active - CW'(1));
    assign width_eff = (r_bin_width == 31'd0) ? 31'd1 : r_bin_width;

    // The difference is exact in 33 bits; a negative one always lands in bin 0.
    assign diff    = {r_sample[SAMPLE_W-1], r_sample} - {r_bin_low[31], r_bin_low};
    assign shifted = {r_rem, r_quo[31]};
    assign trial   = {1'b0, shifted} - {2'b00, width_eff};
    assign ge      = !trial[32];

    always_comb begin
        if (r_neg) begin
            bin_sel = '0;
        end else if (r_quo >= 32'(n_active)) begin
            bin_sel = last_idx;
        end else begin
            bin_sel = IW'(r_quo);
        end
    end

    assign rd_addr  = i_cmd.dump_rd ? r_idx : bin_sel;
    assign out_free = !r_ovalid || o_bin.ready;

    assign o_status.roll_due  = (r_total >= {1'b0, r_roll_limit});
    assign o_status.fwd_en    = r_fwd_en;
    assign o_status.dump_last = (r_idx == last_idx);
    assign o_status.div_done  = (r_step == 5'd31);
    assign o_status.out_free  = out_free;

    assign o_bin.valid      = r_ovalid;
    assign o_bin.bin_number = r_out_num;
    assign o_bin.bin_count  = r_out_count;
    assign o_bin.last_bin   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_low     <= RST_BIN_LOW;
            r_bin_width   <= RST_BIN_WIDTH;
            r_bins_in_use <= RST_BINS_IN_USE;
            r_roll_limit  <= RST_ROLLOVER_LIMIT;
            r_fwd_en      <= RST_FORWARD_ENABLE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BIN_LOW:        r_bin_low     <= signed'(i_cfg_data);
                CFG_BIN_WIDTH:      r_bin_width   <= i_cfg_data[30:0];
                CFG_BINS_IN_USE:    r_bins_in_use <= i_cfg_data[4:0];
                CFG_ROLLOVER_LIMIT: r_roll_limit  <= i_cfg_data[30:0];
                CFG_FORWARD_ENABLE: r_fwd_en      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_total <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= '0;
            r_total <= '0;
        end else if (i_cmd.bin_wr) begin
            r_valid[r_bin] <= 1'b1;
            r_total        <= r_total + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_wr) begin
            r_mem[r_bin] <= (r_rd_ok ? r_rd_data : 32'd0) + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_rd || i_cmd.bin_rd) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_valid[rd_addr];
        end
        if (i_cmd.bin_rd) begin
            r_bin <= bin_sel;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample_value;
        end
        if (i_cmd.div_load) begin
            r_quo  <= diff[31:0];
            r_neg  <= diff[32];
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? trial[30:0] : shifted[30:0];
            r_quo  <= {r_quo[30:0], ge};
            r_step <= r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_start) begin
            r_idx <= '0;
        end else if (i_cmd.dump_push) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.dump_push) begin
            r_ovalid <= 1'b1;
        end else if (o_bin.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_push) begin
            r_out_num   <= BIN_NUM_W'(r_idx);
            r_out_count <= r_rd_ok ? r_rd_data[COUNT_W-1:0] : '0;
            r_out_last  <= (r_idx == last_idx);
        end
    end

endmodule

[hdl/histogram_binner_with_rollover.sv]
// Channel   Direction  Payload                              Handshake
// i_sample  in         sample_value                         valid/ready
// o_bin     out        bin_number, bin_count, last_bin      valid/ready
// cfg       in         i_cfg_index, i_cfg_data              i_cfg_wr_en, no wait
//
// A new item is accepted only after the previous one has passed the rollover check, the
// 32-step restoring divider that forms the bin index, and the bin read and write.
// A forwarded rollover adds a read and a push per bin in use, plus any output stall.
// Reset clears the bin store at once through per-entry valid bits; no clearing pass.
// The last dumped result may wait in the output register while the next item proceeds.
module histogram_binner_with_rollover import hbr_pkg::*; #(
    parameter int MAX_BINS = HBR_MAX_BINS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hbr_sample_if.sink            i_sample,
    hbr_bin_if.source             o_bin
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    assign i_sample.ready = in_ready;

    hbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hbr_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_value (i_sample.sample_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_bin          (o_bin)
    );

endmodule
